[rtl/asf_pkg.sv]
// Shared types, constants and defaults for the aging signal FIFO.
`timescale 1ns / 1ps

package asf_pkg;

   // Default sizing, handed to the top-level parameters
   localparam int DEFAULT_DEPTH        = 16;
   localparam int DEFAULT_SIGNAL_WIDTH = 8;
   localparam int DEFAULT_AGE_WIDTH    = 16;

   // Configuration register file
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int MAX_AGE_W   = 16;
   localparam int NSC_W       = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_AGE   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_SIGNAL = 1'd1;

   localparam logic [MAX_AGE_W-1:0] MAX_AGE_RESET = 16'd10;
   localparam logic [NSC_W-1:0]     NSC_RESET     = 8'd0;

   // Operation codes carried in the func field
   typedef enum logic [1:0] {
      FUNC_PUSH = 2'd0,
      FUNC_POP  = 2'd1,
      FUNC_TICK = 2'd2,
      FUNC_NOP  = 2'd3
   } func_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_item;       // capture the accepted word, clear event flags
      logic push;            // store the word at the tail
      logic pop;             // remove the head, report its signal
      logic mark_drop;       // push refused, FIFO full
      logic mark_pop_empty;  // pop found nothing
      logic age_write;       // write back one aged entry, advance sweep index
      logic expire;          // close the sweep, drop the head if too old
      logic load_rsp;        // load the result register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      func_type op;
      logic     empty;
      logic     full;
      logic     sweep_last;
      logic     rsp_free;
   } status_type;

endpackage

[rtl/asf_req_if.sv]
// Request channel: operation and signal code toward the FIFO.
`timescale 1ns / 1ps

interface asf_req_if #(
   parameter int SIGNAL_WIDTH = 8
);
   logic                    valid;
   logic                    ready;
   logic [1:0]              func;
   logic [SIGNAL_WIDTH-1:0] signal_value;

   modport source (output valid, output func, output signal_value, input ready);
   modport sink   (input valid, input func, input signal_value, output ready);
endinterface

[rtl/asf_rsp_if.sv]
// Response channel: FIFO status after each operation.
`timescale 1ns / 1ps

interface asf_rsp_if #(
   parameter int SIGNAL_WIDTH = 8,
   parameter int COUNT_WIDTH  = 5
);
   logic                    valid;
   logic                    ready;
   logic [SIGNAL_WIDTH-1:0] popped_signal;
   logic [SIGNAL_WIDTH-1:0] head_signal;
   logic [COUNT_WIDTH-1:0]  entry_count;
   logic                    is_empty;
   logic                    is_full;
   logic                    push_dropped;
   logic                    pop_on_empty;
   logic                    expired;

   modport source (
      output valid, output popped_signal, output head_signal, output entry_count,
      output is_empty, output is_full, output push_dropped, output pop_on_empty,
      output expired, input ready
   );
   modport sink (
      input valid, input popped_signal, input head_signal, input entry_count,
      input is_empty, input is_full, input push_dropped, input pop_on_empty,
      input expired, output ready
   );
endinterface

[rtl/asf_controller.sv]
// Operation sequencer for the aging signal FIFO.
`timescale 1ns / 1ps

module asf_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  asf_pkg::status_type status,
   output asf_pkg::cmd_type    cmd
);
   import asf_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_EXEC   = 6'b000010,
      ST_AGE_RD = 6'b000100,
      ST_AGE_WR = 6'b001000,
      ST_LOOK   = 6'b010000,
      ST_FIN    = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_LOOK;
            case (status.op)
               FUNC_PUSH: begin
                  if (status.full) cmd.mark_drop = 1'b1;
                  else             cmd.push      = 1'b1;
               end
               FUNC_POP: begin
                  if (status.empty) cmd.mark_pop_empty = 1'b1;
                  else              cmd.pop            = 1'b1;
               end
               FUNC_TICK: begin
                  if (!status.empty) state_in = ST_AGE_RD;
               end
               default: ;
            endcase
         end
         ST_AGE_RD: state_in = ST_AGE_WR;
         ST_AGE_WR: begin
            cmd.age_write = 1'b1;
            if (status.sweep_last) begin
               cmd.expire = 1'b1;
               state_in   = ST_LOOK;
            end else begin
               state_in   = ST_AGE_RD;
            end
         end
         ST_LOOK: state_in = ST_FIN;
         ST_FIN: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // An accepted word always starts execution next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted word did not enter execution");

   // Never overwrite a result the receiver has not taken
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> status.rsp_free)
      else $error("result register overwritten");

   // Every age write-back follows its read
   a_age_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AGE_WR) |-> ($past(state_ff) == ST_AGE_RD))
      else $error("age write-back without a preceding read");

endmodule

[rtl/asf_datapath.sv]
// Storage, pointers, aging sweep and result register of the aging signal FIFO.
`timescale 1ns / 1ps

module asf_datapath #(
   parameter int DEPTH        = asf_pkg::DEFAULT_DEPTH,
   parameter int SIGNAL_WIDTH = asf_pkg::DEFAULT_SIGNAL_WIDTH,
   parameter int AGE_WIDTH    = asf_pkg::DEFAULT_AGE_WIDTH,
   parameter int COUNT_WIDTH  = $clog2(DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  asf_pkg::cmd_type                  cmd,
   output asf_pkg::status_type               status,
   input  logic [1:0]                        req_func,
   input  logic [SIGNAL_WIDTH-1:0]           req_signal_value,
   input  logic                              csr_write_en,
   input  logic [asf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [asf_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [SIGNAL_WIDTH-1:0]           rsp_popped_signal,
   output logic [SIGNAL_WIDTH-1:0]           rsp_head_signal,
   output logic [COUNT_WIDTH-1:0]            rsp_entry_count,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full,
   output logic                              rsp_push_dropped,
   output logic                              rsp_pop_on_empty,
   output logic                              rsp_expired
);
   import asf_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CMP_W = (AGE_WIDTH > MAX_AGE_W) ? AGE_WIDTH : MAX_AGE_W;
   localparam logic [PTR_W-1:0]       LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W:0]         WRAP      = (PTR_W + 1)'(DEPTH);
   localparam logic [COUNT_WIDTH-1:0] FULL_CNT  = COUNT_WIDTH'(DEPTH);

   // Entry storage
   logic [SIGNAL_WIDTH-1:0] sig_mem [DEPTH];
   logic [AGE_WIDTH-1:0]    age_mem [DEPTH];
   logic [SIGNAL_WIDTH-1:0] rd_sig_ff;
   logic [AGE_WIDTH-1:0]    rd_age_ff;

   // Control state
   logic [PTR_W-1:0]       rp_ff, rp_in;
   logic [PTR_W-1:0]       wp_ff, wp_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [PTR_W-1:0]       idx_ff, idx_in;
   logic [MAX_AGE_W-1:0]   max_age_ff, max_age_in;
   logic [NSC_W-1:0]       nsc_ff, nsc_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Per-item payload
   func_type                op_ff, op_in;
   logic [SIGNAL_WIDTH-1:0] item_sig_ff, item_sig_in;
   logic [SIGNAL_WIDTH-1:0] popped_ff, popped_in;
   logic                    dropped_ff, dropped_in;
   logic                    pop_empty_ff, pop_empty_in;
   logic                    expired_ff, expired_in;
   logic [SIGNAL_WIDTH-1:0] head_sig_ff, head_sig_in;
   logic                    head_over_ff, head_over_in;

   // Result register
   logic [SIGNAL_WIDTH-1:0] out_popped_ff, out_head_ff;
   logic [COUNT_WIDTH-1:0]  out_count_ff;
   logic                    out_empty_ff, out_full_ff;
   logic                    out_dropped_ff, out_pop_empty_ff, out_expired_ff;

   logic [PTR_W:0]          addr_sum;
   logic [PTR_W-1:0]        rd_addr;
   logic [AGE_WIDTH-1:0]    age_inc;
   logic                    age_over;
   logic                    head_over;
   logic [SIGNAL_WIDTH-1:0] head_sig;
   logic [SIGNAL_WIDTH-1:0] nsc_ext;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   // Sweep address: head plus sweep index, wrapped once
   assign addr_sum = {1'b0, rp_ff} + {1'b0, idx_ff};
   assign rd_addr  = (addr_sum >= WRAP) ? PTR_W'(addr_sum - WRAP) : addr_sum[PTR_W-1:0];

   assign age_inc   = (rd_age_ff == '1) ? rd_age_ff : rd_age_ff + 1'b1;
   assign age_over  = CMP_W'(age_inc) > CMP_W'(max_age_ff);
   assign head_over = (idx_ff == '0) ? age_over : head_over_ff;
   assign head_sig  = (idx_ff == '0) ? rd_sig_ff : head_sig_ff;
   assign nsc_ext   = SIGNAL_WIDTH'(nsc_ff);

   assign status.op         = op_ff;
   assign status.empty      = (count_ff == '0);
   assign status.full       = (count_ff == FULL_CNT);
   assign status.sweep_last = (COUNT_WIDTH'(idx_ff) == count_ff - COUNT_WIDTH'(1));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      max_age_in   = max_age_ff;
      nsc_in       = nsc_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      item_sig_in  = item_sig_ff;
      popped_in    = popped_ff;
      dropped_in   = dropped_ff;
      pop_empty_in = pop_empty_ff;
      expired_in   = expired_ff;
      head_sig_in  = head_sig_ff;
      head_over_in = head_over_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_MAX_AGE:   max_age_in = csr_wdata[MAX_AGE_W-1:0];
            CSR_NO_SIGNAL: nsc_in     = csr_wdata[NSC_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load_item) begin
         op_in        = func_type'(req_func);
         item_sig_in  = req_signal_value;
         popped_in    = nsc_ext;
         dropped_in   = 1'b0;
         pop_empty_in = 1'b0;
         expired_in   = 1'b0;
         idx_in       = '0;
      end
      if (cmd.push) begin
         wp_in    = next_slot(wp_ff);
         count_in = count_ff + 1'b1;
      end
      if (cmd.pop) begin
         popped_in = rd_sig_ff;
         rp_in     = next_slot(rp_ff);
         count_in  = count_ff - 1'b1;
      end
      if (cmd.mark_drop)      dropped_in   = 1'b1;
      if (cmd.mark_pop_empty) pop_empty_in = 1'b1;
      if (cmd.age_write) begin
         if (idx_ff == '0) begin
            head_sig_in  = rd_sig_ff;
            head_over_in = age_over;
         end
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.expire) begin
         idx_in = '0;
         if (head_over) begin
            popped_in  = head_sig;
            expired_in = 1'b1;
            rp_in      = next_slot(rp_ff);
            count_in   = count_ff - 1'b1;
         end
      end

      if (cmd.load_rsp)     rsp_valid_in = 1'b1;
      else if (rsp_ready)   rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff        <= '0;
         wp_ff        <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         max_age_ff   <= MAX_AGE_RESET;
         nsc_ff       <= NSC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         max_age_ff   <= max_age_in;
         nsc_ff       <= nsc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      item_sig_ff  <= item_sig_in;
      popped_ff    <= popped_in;
      dropped_ff   <= dropped_in;
      pop_empty_ff <= pop_empty_in;
      expired_ff   <= expired_in;
      head_sig_ff  <= head_sig_in;
      head_over_ff <= head_over_in;
   end

   // Entry memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         sig_mem[wp_ff] <= item_sig_ff;
         age_mem[wp_ff] <= '0;
      end else if (cmd.age_write) begin
         age_mem[rd_addr] <= age_inc;
      end
      rd_sig_ff <= sig_mem[rd_addr];
      rd_age_ff <= age_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         out_popped_ff    <= popped_ff;
         out_head_ff      <= (count_ff == '0) ? nsc_ext : rd_sig_ff;
         out_count_ff     <= count_ff;
         out_empty_ff     <= (count_ff == '0);
         out_full_ff      <= (count_ff == FULL_CNT);
         out_dropped_ff   <= dropped_ff;
         out_pop_empty_ff <= pop_empty_ff;
         out_expired_ff   <= expired_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_popped_signal = out_popped_ff;
   assign rsp_head_signal   = out_head_ff;
   assign rsp_entry_count   = out_count_ff;
   assign rsp_is_empty      = out_empty_ff;
   assign rsp_is_full       = out_full_ff;
   assign rsp_push_dropped  = out_dropped_ff;
   assign rsp_pop_on_empty  = out_pop_empty_ff;
   assign rsp_expired       = out_expired_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count beyond depth");

   // Empty and full both leave the pointers equal
   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_CNT) |-> (rp_ff == wp_ff))
      else $error("pointers disagree with entry count");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not grow the count");

endmodule

[rtl/aging_signal_fifo.sv]
// Top level of the aging signal FIFO: controller, datapath and channel hookup.
`timescale 1ns / 1ps

// Circular FIFO of signal codes; each entry carries an age.
// Request words (req) carry func and signal_value: push, pop oldest, age tick
// (age every entry, then drop the head once if older than max_age), or no-op.
// Each request produces exactly one response word (rsp) with the popped
// signal, the head after the operation, the entry count and event flags.
// Configuration: csr_write_en with csr_index 0 writes max_age, index 1
// writes the no-signal code; write only while the block is idle.
// Push, pop, no-op and a tick on an empty FIFO pass from acceptance through
// execute and a look-up step to a final step that loads the response
// register. A tick on a FIFO holding n entries adds an aging sweep between
// execute and look-up: it reads and then writes back each of the n entries
// in turn through the registered age read.
// One word is in work at a time; req_ready rises again once the response is
// loaded, so the next word can be taken while that response still waits.
// If the receiver stalls, the response holds and the next word waits in its
// final step until the response register is free.
// Reset clears pointers, count and the response valid; config returns to
// max_age 10 and no-signal code 0. Entry storage needs no clearing pass.
module aging_signal_fifo #(
   parameter int DEPTH        = asf_pkg::DEFAULT_DEPTH,
   parameter int SIGNAL_WIDTH = asf_pkg::DEFAULT_SIGNAL_WIDTH,
   parameter int AGE_WIDTH    = asf_pkg::DEFAULT_AGE_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   asf_req_if.sink                         req,
   asf_rsp_if.source                       rsp,
   input  logic                            csr_write_en,
   input  logic [asf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [asf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import asf_pkg::*;

   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   cmd_type    cmd;
   status_type status;

   // Sequencer: walks each word through execute, aging sweep and response
   asf_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage, pointers, config registers and the response register
   asf_datapath #(
      .DEPTH        (DEPTH),
      .SIGNAL_WIDTH (SIGNAL_WIDTH),
      .AGE_WIDTH    (AGE_WIDTH),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_func          (req.func),
      .req_signal_value  (req.signal_value),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp.valid),
      .rsp_ready         (rsp.ready),
      .rsp_popped_signal (rsp.popped_signal),
      .rsp_head_signal   (rsp.head_signal),
      .rsp_entry_count   (rsp.entry_count),
      .rsp_is_empty      (rsp.is_empty),
      .rsp_is_full       (rsp.is_full),
      .rsp_push_dropped  (rsp.push_dropped),
      .rsp_pop_on_empty  (rsp.pop_on_empty),
      .rsp_expired       (rsp.expired)
   );

endmodule
